FILE: design/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Request codes, status codes, storage operation codes and the control word
// passed from the front end to the back end.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int REQ_W    = 3;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 40;
	localparam int M_PAD_W  = M_DATA_W - VAL_W - OCC_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_BACK  = 3'd0,
		REQ_PUSH_FRONT = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_PEEK_FRONT = 3'd4,
		REQ_PEEK_BACK  = 3'd5
	} req_e_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_e_t;

	typedef enum logic [1:0] {
		MOP_NONE  = 2'd0,
		MOP_WRITE = 2'd1,
		MOP_READ  = 2'd2
	} mem_op_e_t;

	typedef struct packed {
		mem_op_e_t        op;
		status_e_t        status;
		logic [OCC_W-1:0] occ;
	} cmd_ctl_t;

endpackage

FILE: design/dq_front.sv
// ----------------------------------------------------------------------------
// dq_front: request decode and ring pointer update
// Accepts a request word, checks it against the current fill, moves the
// front pointer and entry count, and emits a storage command.
// ----------------------------------------------------------------------------
module dq_front #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic [dq_pkg::REQ_W-1:0]      req_type,
	input  logic [dq_pkg::VAL_W-1:0]      push_value,
	output dq_pkg::cmd_ctl_t              cmd_ctl,
	output logic [$clog2(DEPTH)-1:0]      cmd_addr,
	output logic [DATA_WIDTH-1:0]         cmd_wdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	logic [AW-1:0] front_q, front_nxt;
	logic [CW-1:0] count_q, count_nxt;
	logic          full, empty;
	logic [SW-1:0] tail_sum, back_sum;
	logic [AW-1:0] tail_idx, back_idx, front_inc, front_dec;
	dq_pkg::req_e_t req;

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;

	assign tail_sum = SW'(front_q) + SW'(count_q);
	assign back_sum = tail_sum - SW'(1);
	assign tail_idx = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
	assign back_idx = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
	assign front_inc = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + AW'(1);
	assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);

	assign req       = dq_pkg::req_e_t'(req_type);
	assign cmd_wdata = DATA_WIDTH'(push_value);

	always_comb begin
		front_nxt      = front_q;
		count_nxt      = count_q;
		cmd_ctl.op     = dq_pkg::MOP_NONE;
		cmd_ctl.status = dq_pkg::ST_OK;
		cmd_addr       = front_q;
		unique case (req)
			dq_pkg::REQ_PUSH_BACK: begin
				if (full) begin
					cmd_ctl.status = dq_pkg::ST_FULL;
				end else begin
					cmd_ctl.op = dq_pkg::MOP_WRITE;
					cmd_addr   = tail_idx;
					count_nxt  = count_q + CW'(1);
				end
			end
			dq_pkg::REQ_PUSH_FRONT: begin
				if (full) begin
					cmd_ctl.status = dq_pkg::ST_FULL;
				end else begin
					cmd_ctl.op = dq_pkg::MOP_WRITE;
					cmd_addr   = front_dec;
					front_nxt  = front_dec;
					count_nxt  = count_q + CW'(1);
				end
			end
			dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_PEEK_FRONT: begin
				if (empty) begin
					cmd_ctl.status = dq_pkg::ST_EMPTY;
				end else begin
					cmd_ctl.op = dq_pkg::MOP_READ;
					cmd_addr   = front_q;
					if (req == dq_pkg::REQ_POP_FRONT) begin
						front_nxt = front_inc;
						count_nxt = count_q - CW'(1);
					end
				end
			end
			dq_pkg::REQ_POP_BACK, dq_pkg::REQ_PEEK_BACK: begin
				if (empty) begin
					cmd_ctl.status = dq_pkg::ST_EMPTY;
				end else begin
					cmd_ctl.op = dq_pkg::MOP_READ;
					cmd_addr   = back_idx;
					if (req == dq_pkg::REQ_POP_BACK) begin
						count_nxt = count_q - CW'(1);
					end
				end
			end
			default: begin
			end
		endcase
		cmd_ctl.occ = dq_pkg::OCC_W'(count_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (req_valid) begin
			front_q <= front_nxt;
			count_q <= count_nxt;
		end
	end

endmodule

FILE: design/dq_cmdq.sv
// ----------------------------------------------------------------------------
// dq_cmdq: two-entry command queue
// Decouples the request decoder from the storage stage.
// ----------------------------------------------------------------------------
module dq_cmdq #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	logic [W-1:0] slot_q [2];
	logic         wr_ptr_q, rd_ptr_q;
	logic [1:0]   cnt_q;
	logic         push, pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: design/dq_back.sv
// ----------------------------------------------------------------------------
// dq_back: ring storage and result stage
// Executes at most one storage write or read per command and holds the result
// word until it is taken downstream.
// ----------------------------------------------------------------------------
module dq_back #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  dq_pkg::cmd_ctl_t              cmd_ctl,
	input  logic [$clog2(DEPTH)-1:0]      cmd_addr,
	input  logic [DATA_WIDTH-1:0]         cmd_wdata,
	output logic                          res_valid,
	input  logic                          res_ready,
	output dq_pkg::status_e_t             res_status,
	output logic [dq_pkg::VAL_W-1:0]      res_value,
	output logic [dq_pkg::OCC_W-1:0]      res_occ
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_s1;
	logic                  valid_s1;
	dq_pkg::cmd_ctl_t      ctl_s1;
	logic                  out_valid_q;
	dq_pkg::status_e_t     out_status_q;
	logic [dq_pkg::VAL_W-1:0] out_value_q;
	logic [dq_pkg::OCC_W-1:0] out_occ_q;
	logic                  adv_s1, take;

	assign adv_s1    = valid_s1 && (!out_valid_q || res_ready);
	assign take      = cmd_valid && (!valid_s1 || adv_s1);
	assign cmd_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk) begin
		if (take && cmd_ctl.op == dq_pkg::MOP_WRITE) begin
			mem_q[cmd_addr] <= cmd_wdata;
		end
		if (take && cmd_ctl.op == dq_pkg::MOP_READ) begin
			rd_data_s1 <= mem_q[cmd_addr];
		end
		if (take) begin
			ctl_s1 <= cmd_ctl;
		end
		if (adv_s1) begin
			out_status_q <= ctl_s1.status;
			out_occ_q    <= ctl_s1.occ;
			out_value_q  <= (ctl_s1.op == dq_pkg::MOP_READ) ?
				dq_pkg::VAL_W'(rd_data_s1) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid  = out_valid_q;
	assign res_status = out_status_q;
	assign res_value  = out_value_q;
	assign res_occ    = out_occ_q;

endmodule

FILE: design/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque on a ring of DEPTH words
// Push or pop at either end, or peek at either end; one result word per
// request with status, data and entry count.
// ----------------------------------------------------------------------------
// A request word is taken whenever the two-entry command queue has room, so
// requests may arrive every cycle; the decoder updates the ring pointers at
// once, and each result then passes through a queue slot, the read stage and the output register.
// Sustained throughput is one request per cycle while results are taken,
// set by the single storage access per request in the back stage.
module double_ended_queue #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [dq_pkg::S_DATA_W-1:0]        s_tdata,  // push_value
	input  logic [dq_pkg::REQ_W-1:0]           s_tuser,  // req_type
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [dq_pkg::M_DATA_W-1:0]        m_tdata,  // read_value, occupancy
	output logic [dq_pkg::STATUS_W-1:0]        m_tuser   // status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CTL_W = $bits(dq_pkg::cmd_ctl_t);
	localparam int QW = CTL_W + AW + DATA_WIDTH;

	dq_pkg::cmd_ctl_t      f_ctl, b_ctl;
	logic [AW-1:0]         f_addr, b_addr;
	logic [DATA_WIDTH-1:0] f_wdata, b_wdata;
	logic                  q_valid, q_ready, accept;
	dq_pkg::status_e_t     res_status;
	logic [dq_pkg::VAL_W-1:0] res_value;
	logic [dq_pkg::OCC_W-1:0] res_occ;

	assign accept = s_tvalid && s_tready;

	dq_front #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (accept),
		.req_type   (s_tuser),
		.push_value (s_tdata[dq_pkg::VAL_W-1:0]),
		.cmd_ctl    (f_ctl),
		.cmd_addr   (f_addr),
		.cmd_wdata  (f_wdata)
	);

	dq_cmdq #(.W(QW)) u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   ({f_ctl, f_addr, f_wdata}),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  ({b_ctl, b_addr, b_wdata})
	);

	dq_back #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (q_valid),
		.cmd_ready  (q_ready),
		.cmd_ctl    (b_ctl),
		.cmd_addr   (b_addr),
		.cmd_wdata  (b_wdata),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_status (res_status),
		.res_value  (res_value),
		.res_occ    (res_occ)
	);

	assign m_tdata = {{dq_pkg::M_PAD_W{1'b0}}, res_occ, res_value};
	assign m_tuser = res_status;

endmodule

FILE: tb/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue: self-checking bench for the ring-buffer deque
// Drives push, pop, peek and unused request codes with bursty traffic and a
// stalling receiver. A shadow deque predicts status, data and entry count
// for every accepted request word; each result word is checked in order.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;

	localparam int DEPTH        = 16;
	localparam int DATA_WIDTH   = 32;
	localparam int IDX_W        = $clog2(DEPTH);
	localparam int RAND_WORDS   = 850;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;

	// request codes with no operation
	localparam logic [dq_pkg::REQ_W-1:0] REQ_NOP_6 = 3'd6;
	localparam logic [dq_pkg::REQ_W-1:0] REQ_NOP_7 = 3'd7;

	localparam int LEAN_FILL  = 0;
	localparam int LEAN_DRAIN = 1;
	localparam int LEAN_EVEN  = 2;

	typedef struct packed {
		dq_pkg::status_e_t        status;
		logic [dq_pkg::VAL_W-1:0] word;
		logic [dq_pkg::OCC_W-1:0] occ;
	} deque_result_t;

	class deque_shadow;
		logic [DATA_WIDTH-1:0]    ring_words [DEPTH];
		logic [IDX_W-1:0]         front_pos;
		logic [dq_pkg::OCC_W-1:0] entry_cnt;
		deque_result_t            pending_results [$];
		int                       mismatches;

		function new();
			front_pos  = '0;
			entry_cnt  = '0;
			mismatches = 0;
		endfunction

		function void note_request(logic [dq_pkg::REQ_W-1:0] req,
				logic [dq_pkg::VAL_W-1:0] word);
			deque_result_t    res;
			logic [IDX_W-1:0] back_pos;
			res.status = dq_pkg::ST_OK;
			res.word   = '0;
			back_pos   = front_pos + entry_cnt[IDX_W-1:0] - 1'b1;
			case (req)
				dq_pkg::REQ_PUSH_BACK, dq_pkg::REQ_PUSH_FRONT: begin
					if (entry_cnt == DEPTH) begin
						res.status = dq_pkg::ST_FULL;
					end else begin
						if (req == dq_pkg::REQ_PUSH_BACK) begin
							ring_words[front_pos + entry_cnt[IDX_W-1:0]] = word;
						end else begin
							front_pos             = front_pos - 1'b1;
							ring_words[front_pos] = word;
						end
						entry_cnt++;
					end
				end
				dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_PEEK_FRONT: begin
					if (entry_cnt == 0) begin
						res.status = dq_pkg::ST_EMPTY;
					end else begin
						res.word = ring_words[front_pos];
						if (req == dq_pkg::REQ_POP_FRONT) begin
							front_pos = front_pos + 1'b1;
							entry_cnt--;
						end
					end
				end
				dq_pkg::REQ_POP_BACK, dq_pkg::REQ_PEEK_BACK: begin
					if (entry_cnt == 0) begin
						res.status = dq_pkg::ST_EMPTY;
					end else begin
						res.word = ring_words[back_pos];
						if (req == dq_pkg::REQ_POP_BACK)
							entry_cnt--;
					end
				end
				default: ;
			endcase
			res.occ = entry_cnt;
			pending_results.push_back(res);
		endfunction

		function void check_result(logic [dq_pkg::STATUS_W-1:0] status,
				logic [dq_pkg::VAL_W-1:0] word, logic [dq_pkg::OCC_W-1:0] occ);
			deque_result_t res;
			if (pending_results.size() == 0) begin
				$error("result word with none expected: status %0d, read_value %h, occupancy %0d",
					status, word, occ);
				mismatches++;
				return;
			end
			res = pending_results[0];
			pending_results.delete(0);
			if (status !== res.status) begin
				$error("status: expected %0d, actual %0d", res.status, status);
				mismatches++;
			end
			if (word !== res.word) begin
				$error("read_value: expected %h, actual %h", res.word, word);
				mismatches++;
			end
			if (occ !== res.occ) begin
				$error("occupancy: expected %0d, actual %0d", res.occ, occ);
				mismatches++;
			end
		endfunction
	endclass

	logic                        clk      = 1'b0;
	logic                        arst_n   = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [dq_pkg::S_DATA_W-1:0] s_tdata  = '0;
	logic [dq_pkg::REQ_W-1:0]    s_tuser  = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [dq_pkg::M_DATA_W-1:0] m_tdata;
	logic [dq_pkg::STATUS_W-1:0] m_tuser;

	deque_shadow shadow = new();
	int          quiet_cycles = 0;
	int          burst_left = 0;
	int          rx_mode = 0;
	int          rx_left = 0;

	double_ended_queue #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	// receiver: always ready, mostly ready, mostly stalled, or on/off blocks
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(8, 80);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= rx_left[2];
		endcase
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			shadow.note_request(s_tuser, s_tdata[dq_pkg::VAL_W-1:0]);
		if (m_tvalid && m_tready)
			shadow.check_result(m_tuser, m_tdata[dq_pkg::VAL_W-1:0],
				m_tdata[dq_pkg::VAL_W +: dq_pkg::OCC_W]);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic issue(logic [dq_pkg::REQ_W-1:0] req, logic [dq_pkg::VAL_W-1:0] word);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, 10);
			burst_left = $urandom_range(1, 40);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [dq_pkg::REQ_W-1:0] pick_req(int lean);
		int roll;
		int push_pct;
		roll     = $urandom_range(0, 99);
		push_pct = (lean == LEAN_FILL) ? 60 : (lean == LEAN_DRAIN) ? 18 : 40;
		if (roll < 2)
			return REQ_NOP_6;
		if (roll < 4)
			return REQ_NOP_7;
		if (roll < 10)
			return dq_pkg::REQ_PEEK_FRONT;
		if (roll < 16)
			return dq_pkg::REQ_PEEK_BACK;
		if (roll < 16 + push_pct)
			return $urandom_range(0, 1) ? dq_pkg::REQ_PUSH_FRONT : dq_pkg::REQ_PUSH_BACK;
		return $urandom_range(0, 1) ? dq_pkg::REQ_POP_FRONT : dq_pkg::REQ_POP_BACK;
	endfunction

	function automatic logic [dq_pkg::VAL_W-1:0] pick_word();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return $urandom;
	endfunction

	initial begin
		int sent;
		int lean;
		int run_len;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, unused codes
		issue(dq_pkg::REQ_PEEK_FRONT, $urandom);
		issue(dq_pkg::REQ_PEEK_BACK, $urandom);
		issue(dq_pkg::REQ_POP_FRONT, $urandom);
		issue(dq_pkg::REQ_POP_BACK, $urandom);
		issue(REQ_NOP_6, $urandom);
		issue(REQ_NOP_7, $urandom);
		// single entry popped from each end
		issue(dq_pkg::REQ_PUSH_BACK, 32'h0000_0000);
		issue(dq_pkg::REQ_PEEK_FRONT, $urandom);
		issue(dq_pkg::REQ_PEEK_BACK, $urandom);
		issue(dq_pkg::REQ_POP_BACK, $urandom);
		issue(dq_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF);
		issue(dq_pkg::REQ_POP_FRONT, $urandom);
		// fill from both ends, then push into a full queue
		for (int i = 0; i < DEPTH; i++)
			issue((i % 2) ? dq_pkg::REQ_PUSH_FRONT : dq_pkg::REQ_PUSH_BACK, pick_word());
		issue(dq_pkg::REQ_PUSH_BACK, $urandom);
		issue(dq_pkg::REQ_PUSH_FRONT, $urandom);
		issue(dq_pkg::REQ_PEEK_FRONT, $urandom);
		issue(dq_pkg::REQ_PEEK_BACK, $urandom);

		sent = 0;
		while (sent < RAND_WORDS) begin
			lean    = $urandom_range(LEAN_FILL, LEAN_EVEN);
			run_len = $urandom_range(10, 60);
			for (int i = 0; i < run_len; i++) begin
				issue(pick_req(lean), pick_word());
				sent++;
			end
		end
		s_tvalid <= 1'b0;

		while (shadow.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		#1;
		if (shadow.mismatches == 0 && shadow.pending_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
